// ----- sv/dtp_pkg.sv -----
// ----------------------------------------------------------------------------
// dtp_pkg
// Shared types and fixed constants of the degree tail probability unit.
// ----------------------------------------------------------------------------
package dtp_pkg;

  localparam int PROB_FRAC_BITS = 16;
  localparam int PROB_W         = PROB_FRAC_BITS + 1;
  localparam int TDATA_W        = 24;
  localparam int DEG_W          = 7;
  localparam int KEFF_W         = 9;
  localparam int APB_DATA_W     = 32;
  localparam int APB_ADDR_W     = 2;
  localparam int MUL_W          = 36;

  localparam logic [PROB_W-1:0]     PROB_ONE = PROB_W'(1) << PROB_FRAC_BITS;
  localparam logic [APB_ADDR_W-1:0] REG_MIN_DEGREE = 2'd0;

  typedef struct packed {
    logic load;
    logic issue;
    logic finish;
  } dtp_cmd_t;

  typedef struct packed {
    logic last;
    logic out_busy;
  } dtp_status_t;

endpackage

// ----- sv/dtp_ctrl.sv -----
// ----------------------------------------------------------------------------
// dtp_ctrl
// Sequencer: takes one item and sweeps the table once; a final edge's result is handed off.
// ----------------------------------------------------------------------------
module dtp_ctrl import dtp_pkg::*; #(
  parameter int MAX_DEGREE_K = 64,
  parameter int ADDR_W       = 6
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  dtp_status_t       sts,
  output dtp_cmd_t          cmd,
  output logic [ADDR_W-1:0] rd_addr
);

  localparam int CNT_W = $clog2(MAX_DEGREE_K + 2);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_DEGREE_K + 1);
  localparam logic [CNT_W-1:0] CNT_K    = CNT_W'(MAX_DEGREE_K);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_TAIL = 2'd2;

  logic [1:0]       state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          cnt_next   = '0;
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.issue = cnt < CNT_K;
        cnt_next  = cnt + CNT_W'(1);
        if (cnt == CNT_LAST) begin
          state_next = ST_TAIL;
        end
      end
      ST_TAIL: begin
        if (!sts.last) begin
          state_next = ST_IDLE;
        end else if (!sts.out_busy) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign rd_addr = cnt[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

endmodule

// ----- sv/dtp_datapath.sv -----
// ----------------------------------------------------------------------------
// dtp_datapath
// Degree table memory, shared multiply-add with rounding, sum and output stage.
// ----------------------------------------------------------------------------
module dtp_datapath import dtp_pkg::*; #(
  parameter int MAX_DEGREE_K = 64,
  parameter int ADDR_W       = 6
) (
  input  logic              clk,
  input  logic              rst,
  input  dtp_cmd_t          cmd,
  input  logic [ADDR_W-1:0] rd_addr,
  input  logic [PROB_W-1:0] edge_prob,
  input  logic              last_edge,
  input  logic [DEG_W-1:0]  min_degree,
  input  logic              m_tready,
  output dtp_status_t       sts,
  output logic              m_tvalid,
  output logic [PROB_W-1:0] tail_prob
);

  localparam int SUM_W = $clog2(MAX_DEGREE_K) + PROB_W;
  localparam logic signed [MUL_W-1:0] HALF = MUL_W'(1) << (PROB_FRAC_BITS - 1);

  logic [PROB_W-1:0] mem [MAX_DEGREE_K];
  logic [MAX_DEGREE_K-1:0] vld;

  logic [PROB_W-1:0] p_reg;
  logic              last_reg;

  logic              s1_vld, s1_ent_vld;
  logic [ADDR_W-1:0] s1_addr;
  logic [PROB_W-1:0] s1_data;
  logic [PROB_W-1:0] prev;

  logic                    s2_vld;
  logic [ADDR_W-1:0]       s2_addr;
  logic [PROB_W-1:0]       s2_b;
  logic signed [MUL_W-1:0] s2_prod;

  logic [SUM_W-1:0]  sum;
  logic              out_vld;
  logic [PROB_W-1:0] out_data;

  logic [PROB_W-1:0]       cur;
  logic signed [PROB_W:0]  diff;
  logic signed [MUL_W-1:0] rnd, step, new_wide;
  logic [PROB_W-1:0]       new_val;
  logic [KEFF_W-1:0]       k_ext, k_eff;
  logic [PROB_W-1:0]       tail;
  logic [PROB_W-1:0]       p_sat;

  assign p_sat = (edge_prob > PROB_ONE) ? PROB_ONE : edge_prob;

  // entries never written since the last clear read as the reset table
  assign cur = s1_ent_vld ? s1_data : ((s1_addr == '0) ? PROB_ONE : '0);
  assign diff = $signed({1'b0, prev}) - $signed({1'b0, cur});

  assign rnd      = s2_prod + HALF;
  assign step     = rnd >>> PROB_FRAC_BITS;
  assign new_wide = $signed({{(MUL_W-PROB_W){1'b0}}, s2_b}) + step;
  assign new_val  = new_wide[PROB_W-1:0];

  assign k_ext = KEFF_W'(min_degree);
  assign k_eff = (k_ext > KEFF_W'(MAX_DEGREE_K)) ? KEFF_W'(MAX_DEGREE_K) : k_ext;

  always_comb begin
    if (k_eff == '0) begin
      tail = PROB_ONE;
    end else if (sum >= SUM_W'(PROB_ONE)) begin
      tail = '0;
    end else begin
      tail = PROB_ONE - sum[PROB_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      s1_data <= mem[rd_addr];
    end
    if (s2_vld) begin
      mem[s2_addr] <= new_val;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      p_reg <= p_sat;
    end
    s1_addr <= rd_addr;
    s1_ent_vld <= vld[rd_addr];
    s2_addr <= s1_addr;
    s2_b    <= cur;
    s2_prod <= MUL_W'($signed({1'b0, p_reg}) * diff);
    if (out_vld == 1'b0 || m_tready) begin
      if (cmd.finish) begin
        out_data <= tail;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      last_reg <= 1'b0;
      s1_vld   <= 1'b0;
      s2_vld   <= 1'b0;
      prev     <= '0;
      sum      <= '0;
      out_vld  <= 1'b0;
    end else begin
      s1_vld <= cmd.issue;
      s2_vld <= s1_vld;
      if (cmd.load) begin
        last_reg <= last_edge;
        prev     <= '0;
        sum      <= '0;
      end else if (s1_vld) begin
        prev <= cur;
      end
      if (s2_vld) begin
        vld[s2_addr] <= 1'b1;
        if (KEFF_W'(s2_addr) < k_eff) begin
          sum <= sum + SUM_W'(new_val);
        end
      end
      if (cmd.finish) begin
        vld     <= '0;
        out_vld <= 1'b1;
      end else if (m_tready) begin
        out_vld <= 1'b0;
      end
    end
  end

  assign sts.last     = last_reg;
  assign sts.out_busy = out_vld && !m_tready;
  assign m_tvalid     = out_vld;
  assign tail_prob    = out_data;

endmodule

// ----- sv/degree_tail_probability_unit.sv -----
// ----------------------------------------------------------------------------
// degree_tail_probability_unit
// Probability that a vertex of uncertain edges has degree at least k.
// ----------------------------------------------------------------------------
// Edge probabilities arrive one item at a time, the vertex's final edge marked
// by tlast. Each item is taken, the degree table is swept once through a
// single shared multiply-add, one entry per cycle, behind a registered memory
// read and a registered product, and a tail state then ends the item; no new
// item is taken before that. On the final edge the tail probability is placed
// in an output register; the next item may be taken while it waits, but a final
// edge that finds that register still full holds at the end of its sweep until
// it drains. The threshold k must be written at APB address 0 only while idle;
// the block itself does not enforce this.
module degree_tail_probability_unit import dtp_pkg::*; #(
  parameter int MAX_DEGREE_K = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [TDATA_W-1:0]    s_tdata,   // [16:0] edge_prob
  input  logic                  s_tlast,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [TDATA_W-1:0]    m_tdata,   // [16:0] tail_prob
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int ADDR_W = (MAX_DEGREE_K > 1) ? $clog2(MAX_DEGREE_K) : 1;

  logic [DEG_W-1:0]  min_degree;
  logic [ADDR_W-1:0] rd_addr;
  logic [PROB_W-1:0] tail_prob;
  dtp_cmd_t          cmd;
  dtp_status_t       sts;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_MIN_DEGREE) ? APB_DATA_W'(min_degree) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_degree <= DEG_W'(1);
    end else if (psel && penable && pwrite && pready && paddr == REG_MIN_DEGREE) begin
      min_degree <= pwdata[DEG_W-1:0];
    end
  end

  dtp_ctrl #(
    .MAX_DEGREE_K(MAX_DEGREE_K),
    .ADDR_W      (ADDR_W)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .sts     (sts),
    .cmd     (cmd),
    .rd_addr (rd_addr)
  );

  dtp_datapath #(
    .MAX_DEGREE_K(MAX_DEGREE_K),
    .ADDR_W      (ADDR_W)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .rd_addr   (rd_addr),
    .edge_prob (s_tdata[PROB_W-1:0]),
    .last_edge (s_tlast),
    .min_degree(min_degree),
    .m_tready  (m_tready),
    .sts       (sts),
    .m_tvalid  (m_tvalid),
    .tail_prob (tail_prob)
  );

  assign m_tdata = TDATA_W'(tail_prob);

endmodule

// ----- sv/dtp_checker.sv -----
// ----------------------------------------------------------------------------
// dtp_checker
// Port-level checks of the degree tail probability unit, bound to the top.
// ----------------------------------------------------------------------------
module dtp_checker import dtp_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               s_tvalid,
  input logic               s_tready,
  input logic               m_tvalid,
  input logic               m_tready,
  input logic [TDATA_W-1:0] m_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("result changed while stalled");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("item taken during table sweep");

  a_tail_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata <= TDATA_W'(PROB_ONE))
    else $error("tail probability above one");

endmodule

bind degree_tail_probability_unit dtp_checker u_dtp_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata)
);

// ----- test/degree_tail_probability_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// degree_tail_probability_checker
// Predicts and checks the tail probability results of the unit.
// ----------------------------------------------------------------------------
// Keeps its own exact-degree table and threshold. These are updated from the
// accepted input items and from the APB register writes. Each accepted result
// is compared with the oldest predicted tail probability. A result that has no
// prediction waiting counts as a mismatch. The number of predictions still
// waiting is reported to the top level.
// ----------------------------------------------------------------------------
module degree_tail_probability_checker import dtp_pkg::*; #(
  parameter int MAX_DEGREE_K = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [TDATA_W-1:0]    s_tdata,   // [16:0] edge_prob
  input  logic                  s_tlast,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [TDATA_W-1:0]    m_tdata,   // [16:0] tail_prob
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output int                    mismatches,
  output int                    outstanding
);

  logic [PROB_W-1:0] degree_table [MAX_DEGREE_K];
  logic [DEG_W-1:0]  threshold;
  logic [PROB_W-1:0] tail_queue [$];

  // rounded half up: (p*a + (one-p)*b) / one
  function automatic logic [PROB_W-1:0] blend(input logic [PROB_W-1:0] p,
                                              input logic [PROB_W-1:0] a,
                                              input logic [PROB_W-1:0] b);
    logic [63:0] mixed;
    if (p >= PROB_ONE) return a;
    if (p == '0) return b;
    mixed = 64'(p) * 64'(a) + 64'(PROB_ONE - p) * 64'(b) + 64'(PROB_ONE >> 1);
    return PROB_W'(mixed >> PROB_FRAC_BITS);
  endfunction

  always @(posedge clk) begin
    logic [PROB_W-1:0] p;
    logic [PROB_W-1:0] expected;
    logic [31:0]       below_k;
    int                k;
    if (rst) begin
      for (int j = 0; j < MAX_DEGREE_K; j++) degree_table[j] = '0;
      degree_table[0] = PROB_ONE;
      threshold = DEG_W'(1);
      tail_queue.delete();
      mismatches = 0;
      outstanding = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == REG_MIN_DEGREE)
        threshold = pwdata[DEG_W-1:0];
      if (m_tvalid && m_tready) begin
        if (tail_queue.size() == 0) begin
          $display("%0t: unexpected tail_prob, expected none, actual %0d",
                   $time, m_tdata[PROB_W-1:0]);
          mismatches++;
        end else begin
          expected = tail_queue.pop_front();
          if (m_tdata[PROB_W-1:0] !== expected) begin
            $display("%0t: tail_prob mismatch, expected %0d, actual %0d",
                     $time, expected, m_tdata[PROB_W-1:0]);
            mismatches++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        p = s_tdata[PROB_W-1:0];
        if (p > PROB_ONE) p = PROB_ONE;
        for (int j = MAX_DEGREE_K - 1; j > 0; j--)
          degree_table[j] = blend(p, degree_table[j-1], degree_table[j]);
        degree_table[0] = blend(p, '0, degree_table[0]);
        if (s_tlast) begin
          k = (threshold > MAX_DEGREE_K) ? MAX_DEGREE_K : int'(threshold);
          below_k = '0;
          for (int j = 0; j < k; j++) below_k += 32'(degree_table[j]);
          if (k == 0) expected = PROB_ONE;
          else if (below_k >= 32'(PROB_ONE)) expected = '0;
          else expected = PROB_W'(32'(PROB_ONE) - below_k);
          tail_queue.push_back(expected);
          for (int j = 0; j < MAX_DEGREE_K; j++) degree_table[j] = '0;
          degree_table[0] = PROB_ONE;
        end
      end
      outstanding = tail_queue.size();
    end
  end

endmodule

// ----- test/degree_tail_probability_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// degree_tail_probability_unit_tb
// Stimulus and verdict for the degree tail probability unit.
// ----------------------------------------------------------------------------
// A short directed part covers these cases: probabilities of zero and one,
// probabilities above one, a single edge at k of one, a zero threshold, a
// threshold beyond the table, and a threshold changed in the middle of a
// vertex. Random vertices then follow over several threshold settings. Both
// stream sides idle at random. Some phases run with no idling. In one phase
// the receiver holds off for a long stretch. A separate checker does the
// predicting and comparing.
// ----------------------------------------------------------------------------
module degree_tail_probability_unit_tb;
  import dtp_pkg::*;

  localparam int MAX_DEGREE_K    = 64;
  localparam int MAX_GAP         = 17;
  localparam int SETTLE_CYCLES   = 100;
  localparam int HOLD_OFF_CYCLES = 1500;
  localparam int WATCHDOG_LIMIT  = 8000;
  localparam int PHASE_COUNT     = 12;
  localparam int PHASE_ITEMS     = 160;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [TDATA_W-1:0]    s_tdata;   // [16:0] edge_prob
  logic                  s_tlast;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [TDATA_W-1:0]    m_tdata;   // [16:0] tail_prob
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int          mismatches;
  int          outstanding;
  bit          no_idle;
  bit          hold_req;
  int unsigned recv_stall;
  int unsigned idle_cycles;

  degree_tail_probability_unit #(.MAX_DEGREE_K(MAX_DEGREE_K)) uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  degree_tail_probability_checker #(.MAX_DEGREE_K(MAX_DEGREE_K)) tail_check (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic send_edge(input logic [PROB_W-1:0] prob, input logic last);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= TDATA_W'(prob);
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // block idle: no result pending and the last sweep done
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_min_degree(input int k);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_MIN_DEGREE;
    pwdata  <= APB_DATA_W'(k);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [PROB_W-1:0] draw_prob();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 5) return '0;
    if (pick < 10) return PROB_ONE;
    if (pick < 16) return PROB_W'($urandom_range(32'(PROB_ONE) + 1, (1 << PROB_W) - 1));
    if (pick < 26) return PROB_W'($urandom_range(1, 255));
    if (pick < 36) return PROB_ONE - PROB_W'($urandom_range(1, 255));
    return PROB_W'($urandom_range(0, 32'(PROB_ONE)));
  endfunction

  // receiver: random stall per item, one long hold-off on request
  initial begin
    bit hold_taken;
    hold_taken = 1'b0;
    m_tready <= 1'b0;
    recv_stall = $urandom_range(0, MAX_GAP);
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) recv_stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
      if (hold_req && !hold_taken) begin
        recv_stall = HOLD_OFF_CYCLES;
        hold_taken = 1'b1;
      end
      if (recv_stall > 0) begin
        recv_stall--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no item accepted for %0d cycles", $time, idle_cycles);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    int k;
    int sent;
    int pick;
    int degree;
    bit all_one;
    no_idle  = 1'b0;
    hold_req = 1'b0;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tlast  <= 1'b0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // threshold of one from reset: single edges give the edge probability, capped at one
    send_edge('0, 1'b1);
    send_edge(PROB_ONE, 1'b1);
    send_edge(PROB_W'(12345), 1'b1);
    send_edge(PROB_W'(17'h1FFFF), 1'b1);
    send_edge(PROB_ONE + PROB_W'(1), 1'b1);
    send_edge(PROB_W'(1), 1'b1);
    send_edge(PROB_ONE - PROB_W'(1), 1'b1);
    send_edge(PROB_W'(32768), 1'b0);
    send_edge(PROB_W'(32768), 1'b0);
    send_edge(PROB_W'(32768), 1'b1);
    // zero threshold
    settle();
    write_min_degree(0);
    send_edge(PROB_W'(40000), 1'b0);
    send_edge(PROB_W'(17'h0AAAA), 1'b1);
    // full table
    settle();
    write_min_degree(MAX_DEGREE_K);
    send_edge(PROB_W'(17'h15555), 1'b0);
    send_edge(PROB_ONE, 1'b0);
    send_edge(PROB_W'(100), 1'b0);
    send_edge(PROB_W'(60000), 1'b1);
    // threshold beyond the table, then changed within the vertex
    settle();
    write_min_degree(127);
    send_edge(PROB_W'(17'h0AAAA), 1'b0);
    send_edge(PROB_W'(17'h05555), 1'b0);
    settle();
    write_min_degree(2);
    send_edge(PROB_W'(50000), 1'b1);

    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      settle();
      case (phase)
        0: k = 1;
        1: k = 0;
        2: k = MAX_DEGREE_K;
        3: k = 127;
        4: k = MAX_DEGREE_K + 1;
        default: k = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                                 : $urandom_range(0, 12);
      endcase
      write_min_degree(k);
      no_idle = (phase == 3) || (phase == 8);
      if (phase == 5) hold_req = 1'b1;
      sent = 0;
      // a phase may end inside a vertex, which then finishes under the next k
      while (sent < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 85) degree = $urandom_range(1, 12);
        else if (pick < 95) degree = $urandom_range(13, 40);
        else degree = $urandom_range(60, 80);
        all_one = ($urandom_range(0, 9) == 0);
        for (int e = 0; e < degree && sent < PHASE_ITEMS; e++) begin
          send_edge(all_one ? PROB_ONE : draw_prob(), e == degree - 1);
          sent++;
        end
      end
    end

    settle();
    if (mismatches == 0 && outstanding == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/dtp_pkg.sv
sv/dtp_ctrl.sv
sv/dtp_datapath.sv
sv/degree_tail_probability_unit.sv
sv/dtp_checker.sv
test/degree_tail_probability_checker.sv
test/degree_tail_probability_unit_tb.sv
